[hdl/gcd_pkg.sv]
package gcd_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int DIST_FRAC_BITS = 8;
  localparam int TRIG_ITERATIONS = 20;

  localparam int LAT_W = 24;
  localparam int LON_W = 25;
  localparam int DIST_W = 24;
  localparam int RADIUS_W = 16;
  localparam int IN_FIELDS_W = 2 * LAT_W + 2 * LON_W;
  localparam int IN_TDATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DIST_W + 7) / 8) * 8;

  localparam logic [RADIUS_W-1:0] EARTH_RADIUS_RESET = 16'd3961;

  // Degrees to binary angle: 360 * 2^ANGLE_FRAC_BITS = 45 * 2^(3 + ANGLE_FRAC_BITS).
  localparam int DEG_DIV = 45;
  localparam int DEG_HALF = DEG_DIV / 2;
  localparam longint DEG_RECIP = (64'd1 << 32) / DEG_DIV;
  localparam int TURN_SH_HALF = 28 - ANGLE_FRAC_BITS;
  localparam int TURN_SH_FULL = 29 - ANGLE_FRAC_BITS;

  localparam int Q30 = 1 << 30;
  localparam int CORDIC_GAIN = 652032874;
  localparam longint PI_Q29 = 64'd1686629713;
  localparam int SQRT_BITS = 31;
  localparam int DIST_SHIFT = 30 - DIST_FRAC_BITS;
  localparam longint DIST_MAX = (64'd1 << DIST_W) - 1;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

endpackage

[hdl/great_circle_distance.sv]
// Haversine great-circle distance, fully pipelined: one position pair is taken in every
// cycle unless the output stalls. The pipeline is the chain of a degree-to-angle
// conversion (4 stages), a 20-step rotation CORDIC for four angles at once followed by
// one clamp and quadrant stage, three product stages, two 31-stage square roots side by
// side, a 20-step vectoring CORDIC and five scaling stages. When the output item is not
// taken, the whole pipeline holds.
// The radius register may be written only while no item is in flight.
module great_circle_distance (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [gcd_pkg::RADIUS_W-1:0]   cfg_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // first_lat, first_lon, second_lat, second_lon, zero fill.
  input  logic [gcd_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // distance.
  output logic [gcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import gcd_pkg::*;

  localparam int NLANE = 4;
  localparam int MAG_W = 25;
  localparam int Q_W = 20;
  localparam int RM_W = 6;
  localparam int TBL_DEPTH = 1 << RM_W;
  localparam int TBL_W = TURN_SH_FULL;
  localparam int XW = 33;
  localparam int VW = 34;
  localparam int ZW = 32;
  localparam int RW = 2 * SQRT_BITS - 1;
  localparam int TW = RW + 2;

  localparam int ST_MAG = 0;
  localparam int ST_PROD = 1;
  localparam int ST_QR = 2;
  localparam int ST_ANG = 3;
  localparam int ST_ROT = 4;
  localparam int ST_TRIG = ST_ROT + TRIG_ITERATIONS;
  localparam int ST_SQ = ST_TRIG + 1;
  localparam int ST_TERM = ST_SQ + 1;
  localparam int ST_A = ST_TERM + 1;
  localparam int ST_SQRT = ST_A + 1;
  localparam int ST_VEC = ST_SQRT + SQRT_BITS;
  localparam int ST_Z = ST_VEC + TRIG_ITERATIONS;
  localparam int ST_CPROD = ST_Z + 1;
  localparam int ST_C = ST_CPROD + 1;
  localparam int ST_DPROD = ST_C + 1;
  localparam int ST_OUT = ST_DPROD + 1;
  localparam int NSTAGE = ST_OUT + 1;

  localparam logic [1:0] QUAD_FIRST = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD = 2'd2;
  localparam logic [1:0] QUAD_FOURTH = 2'd3;

  logic                       advance;
  logic [NSTAGE-1:0]          vld;
  logic [RADIUS_W-1:0]        earth_radius;

  logic signed [LAT_W-1:0]    in_lat1, in_lat2;
  logic signed [LON_W-1:0]    in_lon1, in_lon2;
  logic signed [MAG_W:0]      raw [NLANE];

  logic [MAG_W-1:0]           mag0 [NLANE];
  logic                       neg0 [NLANE];
  logic [MAG_W+26:0]          prod1 [NLANE];
  logic [MAG_W-1:0]           mag1 [NLANE];
  logic                       neg1 [NLANE];
  logic [Q_W-1:0]             q2 [NLANE];
  logic [RM_W-1:0]            rm2 [NLANE];
  logic                       neg2 [NLANE];
  logic [31:0]                ang3 [NLANE];
  logic [TBL_W-1:0]           tbl_half [TBL_DEPTH];
  logic [TBL_W-1:0]           tbl_full [TBL_DEPTH];

  logic signed [XW-1:0]       rot_x [TRIG_ITERATIONS][NLANE];
  logic signed [XW-1:0]       rot_y [TRIG_ITERATIONS][NLANE];
  logic signed [ZW-1:0]       rot_z [TRIG_ITERATIONS][NLANE];
  logic [1:0]                 rot_q [TRIG_ITERATIONS][NLANE];
  logic signed [31:0]         trig [NLANE];

  logic signed [63:0]         p_lat, p_lon, p_cc, p_term;
  logic [SQRT_BITS-1:0]       sq_lat, sq_lon, sq_lat_t;
  logic signed [31:0]         cc, term;
  logic signed [32:0]         a_sum;
  logic [SQRT_BITS-1:0]       a_val;

  logic [RW-1:0]              sq_rem [SQRT_BITS][2];
  logic [SQRT_BITS-1:0]       sq_root [SQRT_BITS][2];

  logic signed [VW-1:0]       vec_x [TRIG_ITERATIONS];
  logic signed [VW-1:0]       vec_y [TRIG_ITERATIONS];
  logic signed [ZW-1:0]       vec_z [TRIG_ITERATIONS];

  logic [SQRT_BITS-1:0]       z_val;
  logic [61:0]                c_prod;
  logic [61:0]                c_sum;
  logic [31:0]                c_val;
  logic [47:0]                d_prod;
  logic [48:0]                d_sum;
  logic [48:0]                d_val;
  logic [DIST_W-1:0]          distance;

  assign advance = !vld[NSTAGE-1] || m_axis_tready;
  assign s_axis_tready = advance;
  assign m_axis_tvalid = vld[NSTAGE-1];
  assign m_axis_tdata = OUT_TDATA_W'(distance);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NSTAGE-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      earth_radius <= EARTH_RADIUS_RESET;
    end else if (cfg_wen) begin
      earth_radius <= cfg_wdata;
    end
  end

  assign in_lat1 = s_axis_tdata[LAT_W-1:0];
  assign in_lon1 = s_axis_tdata[LAT_W+LON_W-1:LAT_W];
  assign in_lat2 = s_axis_tdata[2*LAT_W+LON_W-1:LAT_W+LON_W];
  assign in_lon2 = s_axis_tdata[IN_FIELDS_W-1:2*LAT_W+LON_W];

  assign raw[0] = (MAG_W+1)'(in_lat2) - (MAG_W+1)'(in_lat1);
  assign raw[1] = (MAG_W+1)'(in_lon2) - (MAG_W+1)'(in_lon1);
  assign raw[2] = (MAG_W+1)'(in_lat1);
  assign raw[3] = (MAG_W+1)'(in_lat2);

  for (genvar m = 0; m < TBL_DEPTH; m++) begin : g_tbl
    localparam longint EH = (m < DEG_DIV) ?
        ((longint'(m) << TURN_SH_HALF) + DEG_HALF) / DEG_DIV : 0;
    localparam longint EF = (m < DEG_DIV) ?
        ((longint'(m) << TURN_SH_FULL) + DEG_HALF) / DEG_DIV : 0;
    assign tbl_half[m] = TBL_W'(EH);
    assign tbl_full[m] = TBL_W'(EF);
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_conv
    logic [MAG_W-1:0] rem_sub;
    logic [Q_W-1:0]   q0;
    logic [6:0]       rem7;
    logic [31:0]      r_turn;

    assign q0 = prod1[l][32+Q_W-1:32];
    assign rem_sub = mag1[l] - MAG_W'(q0 * MAG_W'(DEG_DIV));
    assign rem7 = rem_sub[6:0];
    if (l < 2) begin : g_half
      assign r_turn = (32'(q2[l]) << TURN_SH_HALF) + 32'(tbl_half[rm2[l]]);
    end else begin : g_full
      assign r_turn = (32'(q2[l]) << TURN_SH_FULL) + 32'(tbl_full[rm2[l]]);
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        mag0[l] <= raw[l][MAG_W] ? MAG_W'(-raw[l]) : MAG_W'(raw[l]);
        neg0[l] <= raw[l][MAG_W];
        prod1[l] <= (MAG_W+27)'(mag0[l]) * (MAG_W+27)'(DEG_RECIP);
        mag1[l] <= mag0[l];
        neg1[l] <= neg0[l];
        if (rem7 >= 7'(DEG_DIV)) begin
          q2[l] <= q0 + 1'b1;
          rm2[l] <= RM_W'(rem7 - 7'(DEG_DIV));
        end else begin
          q2[l] <= q0;
          rm2[l] <= rem7[RM_W-1:0];
        end
        neg2[l] <= neg1[l];
        ang3[l] <= neg2[l] ? 32'(-r_turn) : r_turn;
      end
    end
  end

  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_rot
    localparam logic signed [ZW-1:0] AT = ZW'(ATAN_TURNS[i]);
    for (genvar l = 0; l < NLANE; l++) begin : g_lane
      logic signed [XW-1:0] px, py;
      logic signed [ZW-1:0] pz;
      logic [1:0]           pq;
      if (i == 0) begin : g_first
        assign px = XW'(CORDIC_GAIN);
        assign py = '0;
        assign pz = ZW'({2'b00, ang3[l][29:0]});
        assign pq = ang3[l][31:30];
      end else begin : g_rest
        assign px = rot_x[i-1][l];
        assign py = rot_y[i-1][l];
        assign pz = rot_z[i-1][l];
        assign pq = rot_q[i-1][l];
      end
      always_ff @(posedge clk) begin
        if (advance) begin
          if (pz >= 0) begin
            rot_x[i][l] <= px - (py >>> i);
            rot_y[i][l] <= py + (px >>> i);
            rot_z[i][l] <= pz - AT;
          end else begin
            rot_x[i][l] <= px + (py >>> i);
            rot_y[i][l] <= py - (px >>> i);
            rot_z[i][l] <= pz + AT;
          end
          rot_q[i][l] <= pq;
        end
      end
    end
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_trig
    logic signed [XW-1:0] fx, fy;
    logic signed [31:0]   cx, cy, sn, cs;
    assign fx = rot_x[TRIG_ITERATIONS-1][l];
    assign fy = rot_y[TRIG_ITERATIONS-1][l];
    always_comb begin
      if (fx > Q30) cx = 32'(Q30);
      else if (fx < -Q30) cx = 32'(-Q30);
      else cx = 32'(fx);
      if (fy > Q30) cy = 32'(Q30);
      else if (fy < -Q30) cy = 32'(-Q30);
      else cy = 32'(fy);
      case (rot_q[TRIG_ITERATIONS-1][l])
        QUAD_FIRST: begin
          cs = cx;
          sn = cy;
        end
        QUAD_SECOND: begin
          cs = -cy;
          sn = cx;
        end
        QUAD_THIRD: begin
          cs = -cx;
          sn = -cy;
        end
        QUAD_FOURTH: begin
          cs = cy;
          sn = -cx;
        end
        default: begin
          cs = cx;
          sn = cy;
        end
      endcase
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        trig[l] <= (l < 2) ? sn : cs;
      end
    end
  end

  assign p_lat = trig[0] * trig[0];
  assign p_lon = trig[1] * trig[1];
  assign p_cc = trig[2] * trig[3];
  assign p_term = cc * $signed({1'b0, sq_lon});
  assign a_sum = $signed({2'b00, sq_lat_t}) + 33'(term);

  always_ff @(posedge clk) begin
    if (advance) begin
      sq_lat <= p_lat[60:30];
      sq_lon <= p_lon[60:30];
      cc <= p_cc[61:30];
      term <= p_term[61:30];
      sq_lat_t <= sq_lat;
      if (a_sum < 0) a_val <= '0;
      else if (a_sum > Q30) a_val <= SQRT_BITS'(Q30);
      else a_val <= SQRT_BITS'(a_sum);
    end
  end

  for (genvar s = 0; s < SQRT_BITS; s++) begin : g_sqrt
    localparam int J = SQRT_BITS - 1 - s;
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [RW-1:0]        prem;
      logic [SQRT_BITS-1:0] proot;
      logic [TW-1:0]        trial;
      if (s == 0) begin : g_first
        if (l == 0) begin : g_y
          assign prem = RW'(a_val) << 30;
        end else begin : g_x
          assign prem = RW'(SQRT_BITS'(Q30) - a_val) << 30;
        end
        assign proot = '0;
      end else begin : g_rest
        assign prem = sq_rem[s-1][l];
        assign proot = sq_root[s-1][l];
      end
      assign trial = (TW'(proot) << (J + 1)) + (TW'(1) << (2 * J));
      always_ff @(posedge clk) begin
        if (advance) begin
          if (TW'(prem) >= trial) begin
            sq_rem[s][l] <= prem - RW'(trial);
            sq_root[s][l] <= proot | (SQRT_BITS'(1) << J);
          end else begin
            sq_rem[s][l] <= prem;
            sq_root[s][l] <= proot;
          end
        end
      end
    end
  end

  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_vec
    localparam logic signed [ZW-1:0] AT = ZW'(ATAN_TURNS[i]);
    logic signed [VW-1:0] px, py;
    logic signed [ZW-1:0] pz;
    if (i == 0) begin : g_first
      assign px = VW'(sq_root[SQRT_BITS-1][1]);
      assign py = VW'(sq_root[SQRT_BITS-1][0]);
      assign pz = '0;
    end else begin : g_rest
      assign px = vec_x[i-1];
      assign py = vec_y[i-1];
      assign pz = vec_z[i-1];
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        if (py >= 0) begin
          vec_x[i] <= px + (py >>> i);
          vec_y[i] <= py - (px >>> i);
          vec_z[i] <= pz + AT;
        end else begin
          vec_x[i] <= px - (py >>> i);
          vec_y[i] <= py + (px >>> i);
          vec_z[i] <= pz - AT;
        end
      end
    end
  end

  assign c_sum = c_prod + (62'(1) << 28);
  assign d_sum = 49'(d_prod) + (49'(1) << (DIST_SHIFT - 1));
  assign d_val = d_sum >> DIST_SHIFT;

  always_ff @(posedge clk) begin
    if (advance) begin
      if (vec_z[TRIG_ITERATIONS-1] < 0) z_val <= '0;
      else if (vec_z[TRIG_ITERATIONS-1] > Q30) z_val <= SQRT_BITS'(Q30);
      else z_val <= SQRT_BITS'(vec_z[TRIG_ITERATIONS-1]);
      c_prod <= 62'(z_val) * 62'(PI_Q29);
      c_val <= c_sum[60:29];
      d_prod <= 48'(earth_radius) * 48'(c_val);
      if (d_val > 49'(DIST_MAX)) distance <= DIST_W'(DIST_MAX);
      else distance <= d_val[DIST_W-1:0];
    end
  end

  assert property (@(posedge clk) disable iff (rst) !advance |=> $stable(vld))
    else $error("Pipeline valid bits moved while the output was stalled.");

  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Output item present right after reset.");

  assert property (@(posedge clk) disable iff (rst)
      vld[ST_A] |-> (a_val <= SQRT_BITS'(Q30)))
    else $error("Haversine term left the unit interval.");

  assert property (@(posedge clk) disable iff (rst)
      vld[ST_TRIG] |-> (trig[0] <= Q30 && trig[0] >= -Q30 && trig[2] <= Q30 && trig[2] >= -Q30))
    else $error("Sine or cosine outside the clamped range.");

  assert property (@(posedge clk) disable iff (rst)
      vld[ST_Z] |-> (z_val <= SQRT_BITS'(Q30)))
    else $error("Half central angle exceeds a quarter turn.");

endmodule

[bench/tb_great_circle_distance.sv]
module tb_great_circle_distance;
  timeunit 1ns;
  timeprecision 1ps;

  import gcd_pkg::*;

  localparam int LATENCY = 84;
  localparam int NUM_RANDOM = 1030;
  localparam int NUM_ROWS = 13;
  localparam longint CYCLE_LIMIT = 600000;
  localparam logic NO_FIXED = 1'b0;
  localparam logic FIXED = 1'b1;

  typedef struct packed {
    logic [LAT_W-1:0] lat1;
    logic [LON_W-1:0] lon1;
    logic [LAT_W-1:0] lat2;
    logic [LON_W-1:0] lon2;
  } pos_pair_t;

  typedef struct {
    pos_pair_t   pair;
    logic        fixed;
    logic [23:0] want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [RADIUS_W-1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  logic [DIST_W-1:0] pending[$];
  logic [RADIUS_W-1:0] radius_model;
  int mismatches = 0;
  longint cycles = 0;
  bit fast_sink = 1'b0;

  great_circle_distance uut (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > Q30) return Q30;
    if (v < -Q30) return -Q30;
    return v;
  endfunction

  function automatic logic [31:0] deg_to_turn(longint d, int sh);
    longint unsigned mag;
    longint unsigned den;
    logic [31:0] r;
    mag = (d < 0) ? -d : d;
    den = 64'd360 << ANGLE_FRAC_BITS;
    r = 32'(((mag << sh) + den / 2) / den);
    if (d < 0) r = -r;
    return r;
  endfunction

  task automatic rotate_turn(input logic [31:0] ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = CORDIC_GAIN;
    y = 0;
    z = ang[29:0];
    for (int i = 0; i < TRIG_ITERATIONS; i++) begin
      dx = floor_shift(y, i % 32);
      dy = floor_shift(x, i % 32);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURNS[i % 32];
      end else begin
        x += dx; y -= dy; z += ATAN_TURNS[i % 32];
      end
    end
    x = clamp_unit(x);
    y = clamp_unit(y);
    case (ang[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < TRIG_ITERATIONS; i++) begin
      dx = floor_shift(y, i % 32);
      dy = floor_shift(x, i % 32);
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_TURNS[i % 32];
      end else begin
        x -= dx; y += dy; z -= ATAN_TURNS[i % 32];
      end
    end
    if (z < 0) z = 0;
    if (z > Q30) z = Q30;
    return z;
  endfunction

  task automatic haversine_dist(input pos_pair_t p, output logic [DIST_W-1:0] want);
    longint lat1, lon1, lat2, lon2;
    longint s_lat, s_lon, c1, c2, s_tmp, c_tmp, sq_lat, sq_lon, cc, a, ry, rx;
    longint unsigned z, c_q30, d;
    lat1 = longint'($signed(p.lat1));
    lon1 = longint'($signed(p.lon1));
    lat2 = longint'($signed(p.lat2));
    lon2 = longint'($signed(p.lon2));
    rotate_turn(deg_to_turn(lat2 - lat1, 31), s_lat, c_tmp);
    rotate_turn(deg_to_turn(lon2 - lon1, 31), s_lon, c_tmp);
    rotate_turn(deg_to_turn(lat1, 32), s_tmp, c1);
    rotate_turn(deg_to_turn(lat2, 32), s_tmp, c2);
    sq_lat = (s_lat * s_lat) >>> 30;
    sq_lon = (s_lon * s_lon) >>> 30;
    cc = floor_shift(c1 * c2, 30);
    a = sq_lat + floor_shift(cc * sq_lon, 30);
    if (a < 0) a = 0;
    if (a > Q30) a = Q30;
    ry = int_sqrt(longint'(a) << 30);
    rx = int_sqrt(longint'(Q30 - a) << 30);
    z = vector_angle(ry, rx);
    c_q30 = (z * PI_Q29 + (64'd1 << 28)) >> 29;
    d = (longint'(radius_model) * c_q30 + (64'd1 << (DIST_SHIFT - 1))) >> DIST_SHIFT;
    if (d > DIST_MAX) d = DIST_MAX;
    want = d[DIST_W-1:0];
  endtask

  function automatic logic [IN_TDATA_W-1:0] pack_pair(pos_pair_t p);
    logic [IN_TDATA_W-1:0] v;
    v = '0;
    v[LAT_W-1:0] = p.lat1;
    v[LAT_W +: LON_W] = p.lon1;
    v[LAT_W+LON_W +: LAT_W] = p.lat2;
    v[2*LAT_W+LON_W +: LON_W] = p.lon2;
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic pos_pair_t pick_pair();
    pos_pair_t p;
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      p.lat1 = LAT_W'($urandom_range(0, 11796480) - 5898240);
      p.lon1 = LON_W'($urandom_range(0, 23592960) - 11796480);
      if (r < 3) begin
        p.lat2 = p.lat1 + LAT_W'($urandom_range(0, 2000) - 1000);
        p.lon2 = p.lon1 + LON_W'($urandom_range(0, 2000) - 1000);
      end else begin
        p.lat2 = LAT_W'($urandom_range(0, 11796480) - 5898240);
        p.lon2 = LON_W'($urandom_range(0, 23592960) - 11796480);
      end
    end else begin
      p.lat1 = LAT_W'($urandom());
      p.lon1 = LON_W'($urandom());
      p.lat2 = LAT_W'($urandom());
      p.lon2 = LON_W'($urandom());
    end
    return p;
  endfunction

  task automatic send_pair(input pos_pair_t p);
    logic [DIST_W-1:0] d;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    haversine_dist(p, d);
    pending.insert(pending.size(), d);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pack_pair(p);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_radius(input logic [RADIUS_W-1:0] r);
    cfg_wen <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_wen <= 1'b0;
    radius_model = r;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= fast_sink ? 1'b1 : ($urandom_range(0, 99) < 70);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected item: distance %0d", m_axis_tdata);
      end else begin
        if (m_axis_tdata[DIST_W-1:0] !== pending[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: distance expected %0d, actual %0d",
                     pending[0], m_axis_tdata[DIST_W-1:0]);
        end
        void'(pending.pop_front());
      end
    end
  end

  initial begin
    stim_row_t rows[NUM_ROWS];
    stim_row_t row;
    logic [RADIUS_W-1:0] radii[6];
    logic [DIST_W-1:0] d;
    int phase_items;

    radius_model = EARTH_RADIUS_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Identical points give zero at any radius.
    rows[0] = '{'{24'd0, 25'd0, 24'd0, 25'd0}, FIXED, 24'd0};
    rows[1] = '{'{24'h5A0000, 25'h0B40000, 24'h5A0000, 25'h0B40000}, FIXED, 24'd0};
    rows[2] = '{'{24'hA60000, 25'h14C0000, 24'hA60000, 25'h14C0000}, FIXED, 24'd0};
    rows[3] = '{'{24'h5A0000, 25'd0, 24'hA60000, 25'd0}, NO_FIXED, '0};
    rows[4] = '{'{24'd0, 25'h14C0000, 24'd0, 25'h0B40000}, NO_FIXED, '0};
    rows[5] = '{'{24'd0, 25'd0, 24'd0, 25'h0B40000}, NO_FIXED, '0};
    rows[6] = '{'{24'd0, 25'd0, 24'd0, 25'd1}, NO_FIXED, '0};
    rows[7] = '{'{24'd1, 25'd0, 24'd0, 25'd0}, NO_FIXED, '0};
    rows[8] = '{'{24'h7FFFFF, 25'h0FFFFFF, 24'h800000, 25'h1000000}, NO_FIXED, '0};
    rows[9] = '{'{24'h800000, 25'h1000000, 24'h7FFFFF, 25'h0FFFFFF}, NO_FIXED, '0};
    rows[10] = '{'{24'hFFFFFF, 25'h1FFFFFF, 24'hFFFFFF, 25'h1FFFFFF}, NO_FIXED, '0};
    rows[11] = '{'{24'h2A0000, 25'h0000000, 24'h280000, 25'h1FF0000}, NO_FIXED, '0};
    rows[12] = '{'{24'h555555, 25'h0AAAAAA, 24'hAAAAAA, 25'h1555555}, NO_FIXED, '0};

    foreach (rows[i]) begin
      row = rows[i];
      if (row.fixed) begin
        haversine_dist(row.pair, d);
        if (d !== row.want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Table row %0d: expected %0d, model gives %0d", i, row.want, d);
        end
      end
      send_pair(row.pair);
    end
    wait_drained();

    radii = '{16'd65535, 16'd1, 16'd0, 16'd3961, 16'd20000, 16'd65535};
    phase_items = NUM_RANDOM / 6;
    foreach (radii[k]) begin
      write_radius(radii[k]);
      if (k == 2) fast_sink = 1'b1;
      if (k == 4) fast_sink = 1'b0;
      for (int n = 0; n < phase_items; n++) send_pair(pick_pair());
      if (k == 0) begin
        send_pair('{24'h5A0000, 25'd0, 24'hA60000, 25'd0});
        send_pair('{24'd0, 25'd0, 24'd0, 25'h0B40000});
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
